// ===== hdl/nearest_palette_color_quantizer_core_defines.svh =====
// Assertion macros shared by the quantizer RTL files.
`ifndef NEAREST_PALETTE_COLOR_QUANTIZER_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_QUANTIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NPQ_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define NPQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define NPQ_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define NPQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== hdl/npq_pkg.sv =====
// Shared types and constants for the nearest palette color quantizer.
`default_nettype none

package npq_pkg;

    localparam int PAL_DEPTH          = 255;
    localparam int PAL_AW             = 8;
    localparam int COLOR_W            = 24;
    localparam int IDX_W              = 8;
    localparam int DIST_W             = 18;
    localparam int SEARCH_ENTRIES_DEF = 255;

    localparam logic [IDX_W-1:0] TRANSPARENT_INDEX = 8'hFF;
    localparam logic [7:0]       THRESHOLD_RESET   = 8'd128;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUANT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_FINISH
    } npq_state_t;

    typedef struct packed {
        logic              accept;
        logic              capture;
        logic              issue;
        logic [PAL_AW-1:0] rd_addr;
        logic              load_out;
    } npq_cmd_t;

    typedef struct packed {
        logic transparent;
        logic pipe_busy;
        logic out_free;
    } npq_sts_t;

endpackage

`default_nettype wire

// ===== hdl/npq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module npq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 255
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/npq_datapath.sv =====
// Datapath: palette store, distance pipeline, best-match tracking and result register.
`default_nettype none

module npq_datapath
    import npq_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write,
    input  wire logic [7:0]     cfg_data,
    input  wire logic           op,
    input  wire logic [7:0]     entry_index,
    input  wire logic [7:0]     red,
    input  wire logic [7:0]     green,
    input  wire logic [7:0]     blue,
    input  wire logic [7:0]     alpha,
    input  wire logic           out_stall,
    output logic                out_valid,
    output logic [IDX_W-1:0]    color_index,
    input  wire npq_cmd_t       cmd,
    output npq_sts_t            sts
);

`include "nearest_palette_color_quantizer_core_defines.svh"

    logic [7:0]           thr_reg, thr_next;
    logic [PAL_DEPTH-1:0] vld_reg, vld_next;
    logic                 ram_we;
    logic [COLOR_W-1:0]   ram_rdata;
    logic [7:0]           pix_r_reg, pix_g_reg, pix_b_reg;
    logic                 transp_reg;
    logic                 s1_v_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic                 s1_ent_vld_reg;
    logic                 s2_v_reg;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic [15:0]          sq_r_reg, sq_g_reg, sq_b_reg;
    logic [COLOR_W-1:0]   ent;
    logic [7:0]           d_r, d_g, d_b;
    logic [DIST_W-1:0]    sum_sq;
    logic [DIST_W-1:0]    min_sum_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     color_index_reg;

    assign ram_we = cmd.accept && (op == OP_WRITE) && (entry_index != TRANSPARENT_INDEX);

    npq_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_index),
        .wdata ({red, green, blue}),
        .raddr (cmd.rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        thr_next = cfg_write ? cfg_data : thr_reg;
        vld_next = vld_reg;
        if (ram_we)
        begin
            vld_next[entry_index] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            vld_reg       <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            vld_reg       <= vld_next;
            s1_v_reg      <= cmd.issue;
            s2_v_reg      <= s1_v_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // An entry never written reads as black, matching the cleared palette.
    assign ent = s1_ent_vld_reg ? ram_rdata : '0;
    assign d_r = (ent[23:16] >= pix_r_reg) ? ent[23:16] - pix_r_reg : pix_r_reg - ent[23:16];
    assign d_g = (ent[15:8] >= pix_g_reg) ? ent[15:8] - pix_g_reg : pix_g_reg - ent[15:8];
    assign d_b = (ent[7:0] >= pix_b_reg) ? ent[7:0] - pix_b_reg : pix_b_reg - ent[7:0];

    assign sum_sq = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_r_reg    <= red;
            pix_g_reg    <= green;
            pix_b_reg    <= blue;
            transp_reg   <= sts.transparent;
            min_sum_reg  <= '1;
            best_idx_reg <= '0;
        end
        else if (s2_v_reg && (sum_sq < min_sum_reg))
        begin
            min_sum_reg  <= sum_sq;
            best_idx_reg <= s2_idx_reg;
        end
        s1_idx_reg     <= cmd.rd_addr;
        s1_ent_vld_reg <= vld_reg[cmd.rd_addr];
        s2_idx_reg     <= s1_idx_reg;
        sq_r_reg       <= d_r * d_r;
        sq_g_reg       <= d_g * d_g;
        sq_b_reg       <= d_b * d_b;
        if (cmd.load_out)
        begin
            color_index_reg <= transp_reg ? TRANSPARENT_INDEX : best_idx_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign sts.transparent = alpha < thr_reg;
    assign sts.pipe_busy   = s1_v_reg || s2_v_reg;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign color_index = color_index_reg;

    `NPQ_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load_out, out_valid_reg)
    `NPQ_ASSERT_NEXT(a_transp_result, clk, rst_n, cmd.load_out && transp_reg,
                     color_index_reg == TRANSPARENT_INDEX)
    `NPQ_ASSERT_IMP(a_no_capture_in_flight, clk, rst_n, cmd.capture, !sts.pipe_busy)

endmodule

`default_nettype wire

// ===== hdl/npq_ctrl.sv =====
// Controller: accepts transactions and sequences the palette search.
`default_nettype none

module npq_ctrl
    import npq_pkg::*;
#(
    parameter int SEARCH_ENTRIES = SEARCH_ENTRIES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     op,
    output logic          in_stall,
    input  wire npq_sts_t sts,
    output npq_cmd_t      cmd
);

`include "nearest_palette_color_quantizer_core_defines.svh"

    localparam int CNT_W = $clog2(SEARCH_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SEARCH_ENTRIES - 1);

    npq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.accept   = accept;
        cmd.capture  = accept && (op == OP_QUANT);
        cmd.issue    = 1'b0;
        cmd.rd_addr  = PAL_AW'(cnt_reg);
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (cmd.capture)
                begin
                    state_next = sts.transparent ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `NPQ_ASSERT_NEXT(a_search_ends, clk, rst_n,
                     (state_reg == ST_SEARCH) && (cnt_reg == CNT_LAST), state_reg == ST_DRAIN)
    `NPQ_ASSERT_IMP(a_issue_in_range, clk, rst_n, cmd.issue, cnt_reg <= CNT_LAST)
    `NPQ_ASSERT_IMP(a_load_when_done, clk, rst_n, cmd.load_out,
                    sts.out_free && !sts.pipe_busy)

endmodule

`default_nettype wire

// ===== hdl/nearest_palette_color_quantizer_core.sv =====
// Top level of the nearest palette color quantizer.
//
//  Channel   Handshake            Payload
//  in        in_valid / in_stall  op, entry_index, red, green, blue, alpha
//  out       out_valid / out_stall color_index
//  cfg       cfg_write            cfg_data (alpha threshold)
//
// A palette write transaction gives no result.
// A quantize transaction whose alpha is below the threshold skips the search;
// otherwise it makes one palette RAM read per cycle over SEARCH_ENTRIES entries
// through a three-stage read, square and compare pipeline.
// Reset clears the threshold to 128 and marks every palette entry as black.
// A waiting result holds the controller in its final state until it is taken.
`default_nettype none

module nearest_palette_color_quantizer_core
    import npq_pkg::*;
#(
    parameter int SEARCH_ENTRIES = SEARCH_ENTRIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             op,
    input  wire logic [7:0]       entry_index,
    input  wire logic [7:0]       red,
    input  wire logic [7:0]       green,
    input  wire logic [7:0]       blue,
    input  wire logic [7:0]       alpha,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [IDX_W-1:0]      color_index
);

    npq_cmd_t cmd;
    npq_sts_t sts;

    npq_ctrl #(
        .SEARCH_ENTRIES (SEARCH_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    npq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .op          (op),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .color_index (color_index),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire
